### rtl/icmp_receive_classifier_assert.svh
// Assertion macros shared by the ICMP receive classifier RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ICMP_RECEIVE_CLASSIFIER_ASSERT_SVH
`define ICMP_RECEIVE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define ICMP_RC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icmp_rc assertion failed");

// Next-cycle implication, checked out of reset
`define ICMP_RC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icmp_rc assertion failed");

`endif

### rtl/icmp_rc_pkg.sv
// Types, constants and the ones'-complement adder for the ICMP receive classifier.
// No dependencies.
package icmp_rc_pkg;

    // ICMP types and embedded protocol
    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_UNREACH    = 8'd3;
    localparam logic [7:0] TYPE_ECHO       = 8'd8;
    localparam logic [7:0] PROTO_UDP       = 8'd17;

    // Length limits
    localparam logic [15:0] MIN_LEN         = 16'd8;
    localparam logic [15:0] MAX_LEN         = 16'd65515;
    localparam logic [15:0] UNREACH_MIN_LEN = 16'd36;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [5:0]  MIN_IHL_BYTES   = 6'd20;

    // Verdict codes
    localparam logic [2:0] VERDICT_NO_LOCAL_IP    = 3'd0;
    localparam logic [2:0] VERDICT_SHORT          = 3'd1;
    localparam logic [2:0] VERDICT_LONG           = 3'd2;
    localparam logic [2:0] VERDICT_UNREACH_IGNORE = 3'd3;
    localparam logic [2:0] VERDICT_UDP_UNREACH    = 3'd4;
    localparam logic [2:0] VERDICT_OTHER_TYPE     = 3'd5;
    localparam logic [2:0] VERDICT_BAD_CHECKSUM   = 3'd6;
    localparam logic [2:0] VERDICT_ECHO_REPLY     = 3'd7;

    // One message byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] sender_ip;
    } msg_item_t;

    // One verdict
    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] reply_checksum;
        logic [31:0] reply_dest_ip;
        logic [15:0] message_length;
        logic [7:0]  unreach_code;
        logic [31:0] orig_dest_ip;
        logic [15:0] orig_src_port;
        logic [15:0] orig_dest_port;
    } result_item_t;

    // Message state as it stands after the final byte, accumulator to decision
    typedef struct packed {
        logic [15:0] count;
        logic [15:0] verify_sum;
        logic [15:0] reply_sum;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [5:0]  inner_hdr_len;
        logic [7:0]  inner_proto;
        logic [31:0] dest_ip;
        logic [31:0] ports;
        logic [31:0] sender_ip;
    } msg_summary_t;

    // Ones'-complement 16-bit add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'b0, t[16]};
    endfunction

endpackage

### rtl/icmp_rc_accum.sv
// Per-message accumulator: byte count, both running checksums, header captures.
// Depends on icmp_rc_pkg.
module icmp_rc_accum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  icmp_rc_pkg::msg_item_t    item,
    output icmp_rc_pkg::msg_summary_t summary
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] verify_sum_reg, verify_sum_next;
    logic [15:0] reply_sum_reg, reply_sum_next;
    logic [7:0]  pending_reg, pending_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] ports_reg, ports_next;
    logic [31:0] sender_reg, sender_next;

    logic [15:0] idx;
    logic [7:0]  b;
    logic [15:0] word;
    logic [15:0] v_add, r_add;
    logic        reply_part;
    logic [15:0] port_lo, port_hi;

    assign idx = byte_count_reg;
    assign b   = item.data_byte;

    // Header captures
    always_comb
    begin
        type_next   = (idx == 16'd0)  ? b : type_reg;
        sender_next = (idx == 16'd0)  ? item.sender_ip : sender_reg;
        code_next   = (idx == 16'd1)  ? b : code_reg;
        ihl_next    = (idx == 16'd8)  ? {b[3:0], 2'b00} : ihl_reg;
        proto_next  = (idx == 16'd17) ? b : proto_reg;
        dest_next   = (idx >= 16'd24 && idx < 16'd28) ? {dest_reg[23:0], b} : dest_reg;
        port_lo     = {10'b0, ihl_next} + 16'd8;
        port_hi     = {10'b0, ihl_next} + 16'd12;
        ports_next  = (ihl_next >= icmp_rc_pkg::MIN_IHL_BYTES && idx >= port_lo
                       && idx < port_hi) ? {ports_reg[23:0], b} : ports_reg;
    end

    // Checksums: odd index closes a word, even index is padded with a zero low byte
    always_comb
    begin
        word            = idx[0] ? {pending_reg, b} : {b, 8'h00};
        pending_next    = idx[0] ? pending_reg : b;
        reply_part      = (idx >= 16'd4);
        v_add           = icmp_rc_pkg::oc_add(verify_sum_reg, word);
        r_add           = icmp_rc_pkg::oc_add(reply_sum_reg, word);
        verify_sum_next = idx[0] ? v_add : verify_sum_reg;
        reply_sum_next  = (idx[0] && reply_part) ? r_add : reply_sum_reg;
        byte_count_next = (idx != icmp_rc_pkg::COUNT_MAX) ? idx + 16'd1 : idx;
    end

    // State as seen by the final byte's decision
    always_comb
    begin
        summary.count         = byte_count_next;
        summary.verify_sum    = v_add;
        summary.reply_sum     = reply_part ? r_add : reply_sum_reg;
        summary.msg_type      = type_next;
        summary.msg_code      = code_next;
        summary.inner_hdr_len = ihl_next;
        summary.inner_proto   = proto_next;
        summary.dest_ip       = dest_next;
        summary.ports         = ports_next;
        summary.sender_ip     = sender_next;
    end

    // State registers, cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            verify_sum_reg <= '0;
            reply_sum_reg  <= '0;
            pending_reg    <= '0;
            type_reg       <= '0;
            code_reg       <= '0;
            ihl_reg        <= '0;
            proto_reg      <= '0;
            dest_reg       <= '0;
            ports_reg      <= '0;
            sender_reg     <= '0;
        end
        else if (fire)
        begin
            if (item.last_byte)
            begin
                byte_count_reg <= '0;
                verify_sum_reg <= '0;
                reply_sum_reg  <= '0;
                pending_reg    <= '0;
                type_reg       <= '0;
                code_reg       <= '0;
                ihl_reg        <= '0;
                proto_reg      <= '0;
                dest_reg       <= '0;
                ports_reg      <= '0;
                sender_reg     <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                verify_sum_reg <= verify_sum_next;
                reply_sum_reg  <= reply_sum_next;
                pending_reg    <= pending_next;
                type_reg       <= type_next;
                code_reg       <= code_next;
                ihl_reg        <= ihl_next;
                proto_reg      <= proto_next;
                dest_reg       <= dest_next;
                ports_reg      <= ports_next;
                sender_reg     <= sender_next;
            end
        end
    end

endmodule

### rtl/icmp_rc_decide.sv
// Verdict logic: turns the message summary and the local address into a result item.
// Depends on icmp_rc_pkg.
module icmp_rc_decide (
    input  icmp_rc_pkg::msg_summary_t summary,
    input  logic [31:0]               local_ip,
    output icmp_rc_pkg::result_item_t result
);

    logic        unreach_ok;
    logic [15:0] unreach_need;

    // Embedded UDP header must be fully present
    always_comb
    begin
        unreach_need = {10'b0, summary.inner_hdr_len} + 16'd16;
        unreach_ok   = (summary.count >= icmp_rc_pkg::UNREACH_MIN_LEN)
                    && (summary.inner_hdr_len >= icmp_rc_pkg::MIN_IHL_BYTES)
                    && (summary.count >= unreach_need)
                    && (summary.inner_proto == icmp_rc_pkg::PROTO_UDP);
    end

    // Checks in priority order
    always_comb
    begin
        result                = '0;
        result.reply_dest_ip  = summary.sender_ip;
        result.message_length = summary.count;
        if (local_ip == 32'd0)
        begin
            result.verdict = icmp_rc_pkg::VERDICT_NO_LOCAL_IP;
        end
        else if (summary.count < icmp_rc_pkg::MIN_LEN)
        begin
            result.verdict = icmp_rc_pkg::VERDICT_SHORT;
        end
        else if (summary.count > icmp_rc_pkg::MAX_LEN)
        begin
            result.verdict = icmp_rc_pkg::VERDICT_LONG;
        end
        else if (summary.msg_type == icmp_rc_pkg::TYPE_UNREACH)
        begin
            result.unreach_code = summary.msg_code;
            if (unreach_ok)
            begin
                result.verdict        = icmp_rc_pkg::VERDICT_UDP_UNREACH;
                result.orig_dest_ip   = summary.dest_ip;
                result.orig_src_port  = summary.ports[31:16];
                result.orig_dest_port = summary.ports[15:0];
            end
            else
            begin
                result.verdict = icmp_rc_pkg::VERDICT_UNREACH_IGNORE;
            end
        end
        else if (summary.msg_type != icmp_rc_pkg::TYPE_ECHO || summary.msg_code != 8'd0)
        begin
            result.verdict = icmp_rc_pkg::VERDICT_OTHER_TYPE;
        end
        else if (summary.verify_sum != 16'hFFFF)
        begin
            result.verdict = icmp_rc_pkg::VERDICT_BAD_CHECKSUM;
        end
        else
        begin
            // reply type/code word is echo reply with code zero, adding nothing
            result.verdict        = icmp_rc_pkg::VERDICT_ECHO_REPLY;
            result.reply_checksum = ~icmp_rc_pkg::oc_add(summary.reply_sum,
                                        {icmp_rc_pkg::TYPE_ECHO_REPLY, 8'd0});
        end
    end

endmodule

### rtl/icmp_receive_classifier.sv
// ICMPv4 receive classifier. Takes one message byte per cycle while msg_stall is low
// and gives one verdict item on the final byte of each message. An accepted byte lands
// in an input register; once the pipe advances it is folded into the running count and
// checksums and, for a final byte, the verdict is loaded into the result register at
// the end of that same cycle. Both stages move together; while a verdict waits on
// result_stall the input register holds and msg_stall rises once it is full.
// local_ip is written through cfg_valid/cfg_ready (always ready); the user must do so
// only while no message is in flight, which the block does not enforce. A local_ip of
// zero gives every message the no-local-IP verdict. Depends on icmp_rc_pkg,
// icmp_rc_accum, icmp_rc_decide and icmp_receive_classifier_assert.svh.
`include "icmp_receive_classifier_assert.svh"

module icmp_receive_classifier (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    output logic                      msg_stall,
    input  icmp_rc_pkg::msg_item_t    msg_item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output icmp_rc_pkg::result_item_t result_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [31:0]               cfg_data
);

    logic                      in_valid_reg;
    icmp_rc_pkg::msg_item_t    in_item_reg;
    logic                      res_valid_reg, res_valid_next;
    icmp_rc_pkg::result_item_t res_item_reg;
    logic [31:0]               local_ip_reg;
    logic                      advance;
    logic                      fire;
    icmp_rc_pkg::msg_summary_t summary;
    icmp_rc_pkg::result_item_t decided;

    // Handshake: the pipe moves whenever the result register is free or being taken
    assign advance      = !res_valid_reg || !result_stall;
    assign fire         = in_valid_reg && advance;
    assign msg_stall    = in_valid_reg && !advance;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            local_ip_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!msg_stall)
        begin
            in_valid_reg <= msg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid && !msg_stall)
        begin
            in_item_reg <= msg_item;
        end
    end

    icmp_rc_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_item_reg),
        .summary (summary)
    );

    icmp_rc_decide u_decide (
        .summary  (summary),
        .local_ip (local_ip_reg),
        .result   (decided)
    );

    // Result register
    assign res_valid_next = advance ? (fire && in_item_reg.last_byte) : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_item_reg.last_byte)
        begin
            res_item_reg <= decided;
        end
    end

    // A final byte leaves a verdict in the next cycle
    `ICMP_RC_ASSERT_NEXT(a_final_gives_result, fire && in_item_reg.last_byte, res_valid_reg)
    // A byte that is not final never raises a verdict by itself
    `ICMP_RC_ASSERT_NEXT(a_no_spurious_result,
        advance && !(fire && in_item_reg.last_byte), !res_valid_reg)
    // Back-pressure only when both stages are full and the result is held
    `ICMP_RC_ASSERT_NOW(a_stall_cause, msg_stall,
        in_valid_reg && res_valid_reg && result_stall)
    // Embedded header fields only go out with a UDP unreachable verdict
    `ICMP_RC_ASSERT_NOW(a_orig_fields_clear,
        res_valid_reg && res_item_reg.verdict != icmp_rc_pkg::VERDICT_UDP_UNREACH,
        res_item_reg.orig_dest_ip == 32'd0 && res_item_reg.orig_src_port == 16'd0
        && res_item_reg.orig_dest_port == 16'd0)

endmodule
